// ===== rtl/core/vcsw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsw_pkg
// Shared types and constants of the velocity command stop watchdog.
// ----------------------------------------------------------------------------
package vcsw_pkg;

  localparam int SOURCES    = 2;
  localparam int SRC_W      = 4;
  localparam int VEL_W      = 16;
  localparam int LIM_W      = 16;
  localparam int MAG_W      = VEL_W + 1;
  localparam int TICK_W     = 17;
  localparam int LANES      = 6;
  localparam int CFG_ADDR_W = 2;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // Opcodes.
  localparam logic [1:0] OP_VEL    = 2'd0;
  localparam logic [1:0] OP_STATUS = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Goal status codes that count as active.
  localparam logic [2:0] GOAL_ACCEPTED  = 3'd1;
  localparam logic [2:0] GOAL_EXECUTING = 3'd2;

  // Register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_LINEAR_LIMIT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ANGULAR_LIMIT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TICKS    = 2'd2;

  // Reset values of the registers.
  localparam logic [LIM_W-1:0] LINEAR_LIMIT_RST  = 16'd41;
  localparam logic [LIM_W-1:0] ANGULAR_LIMIT_RST = 16'd41;
  localparam logic [LIM_W-1:0] HOLD_TICKS_RST    = 16'd5;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [SRC_W-1:0] source;
    logic             entry_present;
    logic [2:0]       goal_code;
    logic             list_last;
  } vcsw_cmd_t;

  typedef struct packed {
    logic emit_zero;
    logic stopping;
    logic any_goal_active;
  } vcsw_result_t;

  typedef struct packed {
    logic [LIM_W-1:0] linear_limit;
    logic [LIM_W-1:0] angular_limit;
    logic [LIM_W-1:0] hold_ticks;
  } vcsw_cfg_t;

endpackage

// ===== rtl/core/vcsw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsw_if
// Channel interfaces: input words, result words and register writes.
// ----------------------------------------------------------------------------
interface vcsw_in_if;
  import vcsw_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic [SRC_W-1:0]        src_idx;
  logic                    entry_present;
  logic [2:0]              goal_code;
  logic                    list_last;
  logic signed [VEL_W-1:0] lin_x;
  logic signed [VEL_W-1:0] lin_y;
  logic signed [VEL_W-1:0] lin_z;
  logic signed [VEL_W-1:0] ang_x;
  logic signed [VEL_W-1:0] ang_y;
  logic signed [VEL_W-1:0] ang_z;

  modport source (output valid, opcode, src_idx, entry_present, goal_code, list_last,
                  lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, input ready);
  modport sink (input valid, opcode, src_idx, entry_present, goal_code, list_last,
                lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, output ready);
endinterface

interface vcsw_out_if;
  logic valid;
  logic ready;
  logic emit_zero;
  logic stopping;
  logic any_goal_active;

  modport source (output valid, emit_zero, stopping, any_goal_active, input ready);
  modport sink (input valid, emit_zero, stopping, any_goal_active, output ready);
endinterface

interface vcsw_cfg_if;
  import vcsw_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [LIM_W-1:0]      data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ===== rtl/core/vcsw_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsw_lane
// One velocity component: magnitude against its threshold, registered.
// ----------------------------------------------------------------------------
module vcsw_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [vcsw_pkg::VEL_W-1:0] value,
  input  logic [vcsw_pkg::LIM_W-1:0]        limit,
  output logic                              trip_r
);
  import vcsw_pkg::*;

  logic [MAG_W-1:0] ext;
  logic [MAG_W-1:0] mag;
  logic             trip_nxt;

  // The extra bit holds the magnitude of the most negative value.
  assign ext      = {value[VEL_W-1], value};
  assign mag      = value[VEL_W-1] ? (~ext + MAG_W'(1)) : ext;
  assign trip_nxt = mag > {1'b0, limit};

  always_ff @(posedge clk) begin
    if (en) begin
      trip_r <= trip_nxt;
    end
  end

endmodule

// ===== rtl/core/vcsw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsw_ctrl
// Merges the lane trips and keeps goal activity, stop flag and hold count.
// ----------------------------------------------------------------------------
module vcsw_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  vcsw_pkg::vcsw_cmd_t          cmd,
  input  logic [vcsw_pkg::LANES-1:0]   trips,
  input  logic [vcsw_pkg::LIM_W-1:0]   hold_ticks,
  output vcsw_pkg::vcsw_result_t       result
);
  import vcsw_pkg::*;

  logic [SOURCES-1:0] active_r, active_nxt;
  logic               seen_r, seen_nxt;
  logic               stop_r, stop_nxt;
  logic [TICK_W-1:0]  ticks_r, ticks_nxt;
  logic [SOURCES-1:0] src_sel;
  logic               src_ok;
  logic               entry_active;
  logic               seen_any;
  logic               goals;
  logic               trig;
  logic               emit;
  logic [TICK_W-1:0]  tick_inc;

  always_comb begin
    for (int i = 0; i < SOURCES; i++) begin
      src_sel[i] = (cmd.source == SRC_W'(i));
    end
  end

  assign src_ok       = |src_sel;
  assign goals        = |active_r;
  assign trig         = |trips;
  assign entry_active = cmd.entry_present &&
                        (cmd.goal_code == GOAL_ACCEPTED ||
                         cmd.goal_code == GOAL_EXECUTING);
  assign seen_any     = seen_r || entry_active;
  assign tick_inc     = (ticks_r == TICK_MAX) ? ticks_r : ticks_r + TICK_W'(1);

  always_comb begin
    active_nxt = active_r;
    seen_nxt   = seen_r;
    stop_nxt   = stop_r;
    ticks_nxt  = ticks_r;
    emit       = 1'b0;
    case (cmd.opcode)
      OP_VEL: begin
        if (!goals && trig) begin
          stop_nxt  = 1'b1;
          ticks_nxt = '0;
          emit      = 1'b1;
        end
      end
      OP_STATUS: begin
        if (src_ok) begin
          seen_nxt = seen_any;
          if (cmd.list_last) begin
            active_nxt = seen_any ? (active_r | src_sel) : (active_r & ~src_sel);
            seen_nxt   = 1'b0;
            if (|active_nxt) begin
              stop_nxt = 1'b0;
            end
          end
        end
      end
      OP_TICK: begin
        ticks_nxt = tick_inc;
        if (stop_r) begin
          if (tick_inc <= {1'b0, hold_ticks}) begin
            emit = 1'b1;
          end else begin
            stop_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign result.emit_zero       = emit;
  assign result.stopping        = stop_nxt;
  assign result.any_goal_active = |active_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      seen_r   <= 1'b0;
      stop_r   <= 1'b0;
      ticks_r  <= '0;
    end else if (step) begin
      active_r <= active_nxt;
      seen_r   <= seen_nxt;
      stop_r   <= stop_nxt;
      ticks_r  <= ticks_nxt;
    end
  end

  // A stop and an active goal never coexist.
  a_stop_excl_goal: assert property (@(posedge clk) disable iff (!rst_n)
    !(stop_r && goals))
    else $error("stop flag set while a goal is active");

  // A trigger starts a fresh hold.
  a_trigger_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && cmd.opcode == OP_VEL && !goals && trig |=> stop_r && ticks_r == '0)
    else $error("trigger did not restart the hold");

  // A zero word is only due while a stop is in progress.
  a_emit_stopping: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.emit_zero |-> result.stopping)
    else $error("zero emitted without a stop in progress");

  // Ticks only count up or restart on a trigger.
  a_ticks_mono: assert property (@(posedge clk) disable iff (!rst_n)
    step && cmd.opcode != OP_VEL |=> ticks_r >= $past(ticks_r))
    else $error("hold count went backward");

endmodule

// ===== rtl/core/velocity_command_stop_watchdog_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_command_stop_watchdog_core
// Stops the robot with zero velocity words when commands over the limits arrive without goals.
// ----------------------------------------------------------------------------
// Path: an accepted input word is registered in the lane compare stage, and its
// result is registered by the state update stage when the output register frees.
// Throughput: one word per cycle unless the sink stalls; the state loop sets it.
// Reset: rst_n clears goal activity, the stop flag, the hold count and both
// pipeline valids, and returns the registers to their defaults (41, 41, 5).
module velocity_command_stop_watchdog_core (
  input logic clk,
  input logic rst_n,
  vcsw_in_if.sink    in_ch,
  vcsw_out_if.source out_ch,
  vcsw_cfg_if.sink   cfg_ch
);
  import vcsw_pkg::*;

  vcsw_cfg_t    cfg_r;
  logic         s1_valid_r;
  vcsw_cmd_t    s1_cmd_r;
  logic         out_valid_r;
  vcsw_result_t out_r;
  vcsw_result_t result;
  logic [LANES-1:0]              trips;
  logic signed [VEL_W-1:0]       comp   [LANES];
  logic [LIM_W-1:0]              limits [LANES];
  logic         in_fire;
  logic         advance;

  // Register writes.
  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.linear_limit  <= LINEAR_LIMIT_RST;
      cfg_r.angular_limit <= ANGULAR_LIMIT_RST;
      cfg_r.hold_ticks    <= HOLD_TICKS_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        REG_LINEAR_LIMIT:  cfg_r.linear_limit  <= cfg_ch.data;
        REG_ANGULAR_LIMIT: cfg_r.angular_limit <= cfg_ch.data;
        REG_HOLD_TICKS:    cfg_r.hold_ticks    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Pipeline handshake: the state stage moves when the output register frees.
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = rst_n && (!s1_valid_r || advance);
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign comp[0]   = in_ch.lin_x;
  assign comp[1]   = in_ch.lin_y;
  assign comp[2]   = in_ch.lin_z;
  assign comp[3]   = in_ch.ang_x;
  assign comp[4]   = in_ch.ang_y;
  assign comp[5]   = in_ch.ang_z;
  assign limits[0] = cfg_r.linear_limit;
  assign limits[1] = cfg_r.linear_limit;
  assign limits[2] = cfg_r.linear_limit;
  assign limits[3] = cfg_r.angular_limit;
  assign limits[4] = cfg_r.angular_limit;
  assign limits[5] = cfg_r.angular_limit;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    vcsw_lane u_lane (
      .clk    (clk),
      .en     (in_fire),
      .value  (comp[g]),
      .limit  (limits[g]),
      .trip_r (trips[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r.opcode        <= in_ch.opcode;
      s1_cmd_r.source        <= in_ch.src_idx;
      s1_cmd_r.entry_present <= in_ch.entry_present;
      s1_cmd_r.goal_code     <= in_ch.goal_code;
      s1_cmd_r.list_last     <= in_ch.list_last;
    end
  end

  vcsw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .cmd        (s1_cmd_r),
    .trips      (trips),
    .hold_ticks (cfg_r.hold_ticks),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.emit_zero       = out_r.emit_zero;
  assign out_ch.stopping        = out_r.stopping;
  assign out_ch.any_goal_active = out_r.any_goal_active;

  // A held result word is not overwritten while the sink stalls.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !advance)
    else $error("result word overwritten during stall");

  // The compare stage never drops a word it holds.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("pipeline word lost");

  // The state stage only runs on a word in flight.
  a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> s1_valid_r)
    else $error("state update without a word");

endmodule
